/* rtl/gm_pkg.sv */
`timescale 1ns / 1ps
// gm_pkg: constants, state type and helper functions for the geometric median block
// no dependencies

package gm_pkg;

	localparam int unsigned MAX_POINTS = 1024;
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned PW = 96;

	localparam logic [1:0] REG_MAX_ITER = 2'd0;
	localparam logic [1:0] REG_TOL      = 2'd1;
	localparam logic [1:0] REG_START_Z  = 2'd2;

	localparam logic [6:0]  MAX_ITER_RST = 7'd9;
	localparam logic [15:0] TOL_RST      = 16'd7;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ITER,
		ST_RD,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_MS,
		ST_SQGO,
		ST_SQ,
		ST_DN,
		ST_DD,
		ST_NEXT,
		ST_STEP,
		ST_SD,
		ST_DONE
	} state_t;

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] m;
		m = v[32] ? 33'(-v) : 33'(v);
		return m[31:0];
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

/* rtl/gm_if.sv */
`timescale 1ns / 1ps
// gm_in_if / gm_out_if: valid-ready channels for point beats and result beats
// no dependencies

interface gm_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic signed [31:0] pz;
	logic               last;
	modport source(output valid, output px, output py, output pz, output last, input ready);
	modport sink(input valid, input px, input py, input pz, input last, output ready);
endinterface

interface gm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] z_result;
	logic        [6:0]  iterations_used;
	logic               converged;
	logic               degenerate;
	logic               overflowed;
	modport source(output valid, output z_result, output iterations_used, output converged,
		output degenerate, output overflowed, input ready);
	modport sink(input valid, input z_result, input iterations_used, input converged,
		input degenerate, input overflowed, output ready);
endinterface

/* rtl/gm_ram.sv */
`timescale 1ns / 1ps
// gm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module gm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/gm_sqrt.sv */
`timescale 1ns / 1ps
// gm_sqrt: bit-serial integer square root of a 64-bit value
// no dependencies

module gm_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] t;

	assign t = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

/* rtl/gm_div.sv */
`timescale 1ns / 1ps
// gm_div: restoring unsigned 64 by 64 divider, one quotient bit per cycle
// no dependencies

module gm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] q_q;
	logic [63:0] dsr_q;
	logic [64:0] rem_sh;

	assign rem_sh = {rem_q, q_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dsr_q}) begin
				rem_q <= 64'(rem_sh - {1'b0, dsr_q});
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

/* rtl/axis_geometric_median.sv */
`timescale 1ns / 1ps
// axis_geometric_median: top level, point store, iteration sequencer and result register
// depends on gm_pkg, gm_if, gm_ram, gm_sqrt, gm_div
//
// Usage: points (px, py, pz in signed Q16.16) arrive on s_in, one beat per cycle while
// s_in.ready is high, and are written to a 1024-entry point memory. The beat with last
// set closes the set; s_in.ready then stays low while Weiszfeld iterations run along z.
// Points beyond the memory size are dropped and reported through overflowed.
// Each iteration walks the memory one point at a time: memory read, three squares on a
// shared multiplier, a square root and two divisions (skipped at zero distance) per
// stored point, then a final step division.
// The result beat on m_out is held in an output register until m_out.ready; loading of
// the next set goes on meanwhile, and only a further result waits for the slot.
// Configuration registers (max_iterations, tolerance, start_z) are written through
// cfg_we / cfg_index / cfg_data; the user must do so while the block is idle (not enforced).
// Reset clears the point count, the overflow flag, the result slot and the registers to
// their defaults; the memory is not cleared and needs no clearing pass.

module axis_geometric_median (
	input  logic        clk,
	input  logic        arst_n,
	gm_in_if.sink       s_in,
	gm_out_if.source    m_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	gm_pkg::state_t state_q, state_d;

	logic [6:0]  max_iter_q;
	logic [15:0] tol_q;
	logic signed [31:0] start_z_q;

	logic [gm_pkg::CW-1:0] cnt_q;
	logic [gm_pkg::CW-1:0] idx_q;
	logic                  ovf_q;
	logic signed [31:0]    z_q;
	logic [6:0]            it_q;
	logic signed [63:0]    num_q;
	logic signed [63:0]    den_q;
	logic [63:0]           mul_q;
	logic [63:0]           s_q;
	logic signed [32:0]    dz_q;
	logic [31:0]           d_q;
	logic                  conv_q;
	logic                  degen_q;

	logic                  out_valid_q;
	logic signed [31:0]    out_z_q;
	logic [6:0]            out_it_q;
	logic                  out_conv_q;
	logic                  out_degen_q;
	logic                  out_ovf_q;

	logic                  in_acc;
	logic                  full;
	logic [gm_pkg::PW-1:0] rd_data;
	logic signed [31:0]    rd_x, rd_y, rd_z;
	logic signed [32:0]    dz;
	logic [31:0]           mul_a;
	logic                  ram_re;
	logic                  sq_start, sq_done;
	logic [31:0]           sq_root;
	logic                  dv_start, dv_done;
	logic [63:0]           dv_dividend, dv_divisor, dv_q;
	logic [63:0]           num_mag;
	logic signed [63:0]    term;
	logic signed [65:0]    znew_w;
	logic signed [31:0]    znew;
	logic signed [32:0]    diff;
	logic                  is_conv;
	logic                  out_load;

	assign full   = (cnt_q == gm_pkg::CW'(gm_pkg::MAX_POINTS));
	assign in_acc = s_in.valid && s_in.ready;
	assign rd_x   = rd_data[31:0];
	assign rd_y   = rd_data[63:32];
	assign rd_z   = rd_data[95:64];
	assign dz     = {z_q[31], z_q} - {rd_z[31], rd_z};
	assign num_mag = num_q[63] ? 64'(-num_q) : 64'(num_q);

	gm_ram #(
		.WIDTH(gm_pkg::PW),
		.DEPTH(gm_pkg::MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (in_acc && !full),
		.waddr(cnt_q[gm_pkg::AW-1:0]),
		.wdata({s_in.pz, s_in.py, s_in.px}),
		.re   (ram_re),
		.raddr(idx_q[gm_pkg::AW-1:0]),
		.rdata(rd_data)
	);

	gm_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.v     (s_q),
		.done  (sq_done),
		.root  (sq_root)
	);

	gm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dv_start),
		.dividend(dv_dividend),
		.divisor (dv_divisor),
		.done    (dv_done),
		.quotient(dv_q)
	);

	// step result and convergence test
	always_comb begin
		term    = num_q[63] ? -$signed(dv_q) : $signed(dv_q);
		znew_w  = 66'(z_q) - 66'(term);
		if (znew_w > 66'sd2147483647) begin
			znew = 32'sh7fffffff;
		end else if (znew_w < -66'sd2147483648) begin
			znew = 32'sh80000000;
		end else begin
			znew = znew_w[31:0];
		end
		diff    = {z_q[31], z_q} - {znew[31], znew};
		is_conv = gm_pkg::mag33(diff) < {16'd0, tol_q};
	end

	always_comb begin
		state_d     = state_q;
		ram_re      = 1'b0;
		sq_start    = 1'b0;
		dv_start    = 1'b0;
		dv_dividend = 64'd1 << 46;
		dv_divisor  = {32'd0, d_q};
		mul_a       = gm_pkg::mag33(dz);
		out_load    = 1'b0;
		s_in.ready  = 1'b0;
		case (state_q)
			gm_pkg::ST_LOAD: begin
				s_in.ready = 1'b1;
				if (in_acc && s_in.last) begin
					state_d = gm_pkg::ST_ITER;
				end
			end
			gm_pkg::ST_ITER: begin
				state_d = (it_q >= max_iter_q) ? gm_pkg::ST_DONE : gm_pkg::ST_RD;
			end
			gm_pkg::ST_RD: begin
				ram_re  = 1'b1;
				state_d = gm_pkg::ST_MX;
			end
			gm_pkg::ST_MX: begin
				mul_a   = gm_pkg::mag33({rd_x[31], rd_x});
				state_d = gm_pkg::ST_MY;
			end
			gm_pkg::ST_MY: begin
				mul_a   = gm_pkg::mag33({rd_y[31], rd_y});
				state_d = gm_pkg::ST_MZ;
			end
			gm_pkg::ST_MZ: state_d = gm_pkg::ST_MS;
			gm_pkg::ST_MS: state_d = gm_pkg::ST_SQGO;
			gm_pkg::ST_SQGO: begin
				sq_start = 1'b1;
				state_d  = gm_pkg::ST_SQ;
			end
			gm_pkg::ST_SQ: begin
				dv_dividend = {2'b00, gm_pkg::mag33(dz_q), 30'd0};
				dv_divisor  = {32'd0, sq_root};
				if (sq_done) begin
					if (sq_root == '0) begin
						state_d = gm_pkg::ST_NEXT;
					end else begin
						dv_start = 1'b1;
						state_d  = gm_pkg::ST_DN;
					end
				end
			end
			gm_pkg::ST_DN: begin
				if (dv_done) begin
					dv_start = 1'b1;
					state_d  = gm_pkg::ST_DD;
				end
			end
			gm_pkg::ST_DD: begin
				if (dv_done) begin
					state_d = gm_pkg::ST_NEXT;
				end
			end
			gm_pkg::ST_NEXT: begin
				state_d = (idx_q + 1'b1 == cnt_q) ? gm_pkg::ST_STEP : gm_pkg::ST_RD;
			end
			gm_pkg::ST_STEP: begin
				dv_dividend = {num_mag[47:0], 16'd0};
				dv_divisor  = den_q;
				if (den_q == '0) begin
					state_d = gm_pkg::ST_DONE;
				end else begin
					dv_start = 1'b1;
					state_d  = gm_pkg::ST_SD;
				end
			end
			gm_pkg::ST_SD: begin
				if (dv_done) begin
					state_d = is_conv ? gm_pkg::ST_DONE : gm_pkg::ST_ITER;
				end
			end
			gm_pkg::ST_DONE: begin
				if (!out_valid_q || m_out.ready) begin
					out_load = 1'b1;
					state_d  = gm_pkg::ST_LOAD;
				end
			end
			default: state_d = gm_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= gm_pkg::MAX_ITER_RST;
			tol_q      <= gm_pkg::TOL_RST;
			start_z_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gm_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[6:0];
				gm_pkg::REG_TOL:      tol_q      <= cfg_data[15:0];
				gm_pkg::REG_START_Z:  start_z_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
			end else if (m_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gm_pkg::ST_LOAD: begin
				if (in_acc && s_in.last) begin
					z_q     <= start_z_q;
					it_q    <= '0;
					conv_q  <= 1'b0;
					degen_q <= 1'b0;
				end
			end
			gm_pkg::ST_ITER: begin
				num_q <= '0;
				den_q <= '0;
				idx_q <= '0;
			end
			gm_pkg::ST_MX: mul_q <= mul_a * mul_a;
			gm_pkg::ST_MY: begin
				s_q   <= mul_q;
				mul_q <= mul_a * mul_a;
			end
			gm_pkg::ST_MZ: begin
				s_q   <= gm_pkg::sat_add64(s_q, mul_q);
				mul_q <= mul_a * mul_a;
				dz_q  <= dz;
			end
			gm_pkg::ST_MS: s_q <= gm_pkg::sat_add64(s_q, mul_q);
			gm_pkg::ST_SQ: begin
				if (sq_done) begin
					d_q <= sq_root;
				end
			end
			gm_pkg::ST_DN: begin
				if (dv_done) begin
					num_q <= num_q + (dz_q[32] ? -$signed(dv_q) : $signed(dv_q));
				end
			end
			gm_pkg::ST_DD: begin
				if (dv_done) begin
					den_q <= den_q + $signed(dv_q);
				end
			end
			gm_pkg::ST_NEXT: idx_q <= idx_q + 1'b1;
			gm_pkg::ST_STEP: begin
				if (den_q == '0) begin
					degen_q <= 1'b1;
				end
			end
			gm_pkg::ST_SD: begin
				if (dv_done) begin
					if (is_conv) begin
						conv_q <= 1'b1;
					end else begin
						z_q  <= znew;
						it_q <= it_q + 7'd1;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_z_q     <= z_q;
			out_it_q    <= it_q;
			out_conv_q  <= conv_q;
			out_degen_q <= degen_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_out.valid           = out_valid_q;
	assign m_out.z_result        = out_z_q;
	assign m_out.iterations_used = out_it_q;
	assign m_out.converged       = out_conv_q;
	assign m_out.degenerate      = out_degen_q;
	assign m_out.overflowed      = out_ovf_q;

endmodule

/* rtl/gm_checker.sv */
`timescale 1ns / 1ps
// gm_checker: port-level checks on the geometric median top level, with its bind
// depends on axis_geometric_median

module gm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic        conv,
	input logic        degen,
	input logic [31:0] z_result
);

	// a closing beat starts the computation, so input stalls right after it
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input still ready after closing beat");

	// a result is never both converged and degenerate
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(conv && degen))
		else $error("converged and degenerate both set");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(z_result))
		else $error("result beat changed while stalled");

endmodule

bind axis_geometric_median gm_checker u_gm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (s_in.valid),
	.in_ready (s_in.ready),
	.in_last  (s_in.last),
	.out_valid(m_out.valid),
	.out_ready(m_out.ready),
	.conv     (m_out.converged),
	.degen    (m_out.degenerate),
	.z_result (m_out.z_result)
);
